// File: rtl/lseu_pkg.sv
// lseu_pkg: shared types, codes and constants of the load/store execute unit
// used by lseu_alu and load_store_execute_unit; no dependencies
`default_nettype none

package lseu_pkg;

	localparam int DATA_W = 32;
	localparam int PC_W   = 11;
	localparam int IDX_W  = 4;
	localparam int TGT_W  = 10;
	localparam int OP_W   = 5;
	localparam int IN_W   = 96;
	localparam int OUT_W  = 48;

	localparam int REG_COUNT_DEF     = 10;
	localparam int MEMORY_WORDS_DEF  = 256;
	localparam int PROGRAM_LINES_DEF = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_NOP = 5'd0,
		OP_MOV = 5'd1,
		OP_ADD = 5'd2,
		OP_SUB = 5'd3,
		OP_LSL = 5'd4,
		OP_LSR = 5'd5,
		OP_LDR = 5'd6,
		OP_STR = 5'd7,
		OP_CMP = 5'd8,
		OP_B   = 5'd9,
		OP_BEQ = 5'd10,
		OP_BNE = 5'd11,
		OP_BLT = 5'd12,
		OP_BLE = 5'd13,
		OP_BGT = 5'd14,
		OP_BGE = 5'd15,
		OP_RET = 5'd16
	} op_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_RET   = 2'd1,
		ST_FAULT = 2'd2,
		ST_PAST  = 2'd3
	} status_t;

	localparam logic [1:0] CMP_EQ = 2'b00;
	localparam logic [1:0] CMP_GT = 2'b01;
	localparam logic [1:0] CMP_LT = 2'b11;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [1:0]        cmp;
	} alu_res_t;

endpackage

`default_nettype wire

// File: rtl/lseu_ram.sv
// lseu_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module lseu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/lseu_alu.sv
// lseu_alu: register/immediate arithmetic, shifts and signed compare
// depends on lseu_pkg
`default_nettype none

module lseu_alu (
	input  wire lseu_pkg::op_t                 op,
	input  wire logic [lseu_pkg::DATA_W-1:0]   a,
	input  wire logic [lseu_pkg::DATA_W-1:0]   b,
	output lseu_pkg::alu_res_t                 res
);

	always_comb begin
		unique case (op)
			lseu_pkg::OP_MOV: res.value = a;
			lseu_pkg::OP_ADD: res.value = a + b;
			lseu_pkg::OP_SUB: res.value = a - b;
			lseu_pkg::OP_LSL: res.value = a << b[4:0];
			lseu_pkg::OP_LSR: res.value = $unsigned($signed(a) >>> b[4:0]);
			default:          res.value = '0;
		endcase
		if ($signed(a) < $signed(b)) begin
			res.cmp = lseu_pkg::CMP_LT;
		end else if ($signed(a) > $signed(b)) begin
			res.cmp = lseu_pkg::CMP_GT;
		end else begin
			res.cmp = lseu_pkg::CMP_EQ;
		end
	end

endmodule

`default_nettype wire

// File: rtl/load_store_execute_unit.sv
// load_store_execute_unit: executes one pre-decoded instruction per transaction
// depends on lseu_pkg, lseu_ram, lseu_alu
//
// usage:
//   cfg_valid/cfg_ready/cfg_data writes program_length; cfg_ready is always high,
//   write only while no instruction is in flight
//   s_axis carries one instruction per transaction, m_axis returns one result each
//   an accepted instruction passes stage 1, stage 2 and the output register to m_axis
//   no new instruction is accepted while the previous one is in stage 1; the register
//   file read and the data memory read are synchronous ram reads, and the next
//   instruction is accepted in the cycle in which the previous one writes back
//   register writes that land on the accept edge are forwarded to the new reader
//   reset: state clears, then a sweep zeroes the data memory, one word per cycle,
//   covering all MEMORY_WORDS words; s_axis_tready stays low during the sweep
//   stall: a result waits in the output register while m_axis_tready is low; the
//   next instruction is fetched in but held at writeback, and s_axis_tready drops
//   after a halt every instruction returns the frozen pc, status and flag
`default_nettype none

module load_store_execute_unit #(
	parameter int REGISTER_COUNT = lseu_pkg::REG_COUNT_DEF,
	parameter int MEMORY_WORDS   = lseu_pkg::MEMORY_WORDS_DEF,
	parameter int PROGRAM_LINES  = lseu_pkg::PROGRAM_LINES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lseu_pkg::PC_W-1:0]   cfg_data,      // program_length
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// operation, first_reg, a_is_reg, a_reg, a_imm, b_is_reg, b_reg, b_imm, target_line
	input  wire logic [lseu_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// next_pc, status, result_value, compare_state
	output logic      [lseu_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int RAW = $clog2(REGISTER_COUNT);
	localparam int MAW = $clog2(MEMORY_WORDS);
	localparam int DW  = lseu_pkg::DATA_W;
	localparam int PW  = lseu_pkg::PC_W;
	localparam int XW  = lseu_pkg::IDX_W;
	localparam int TW  = lseu_pkg::TGT_W;

	function automatic logic reg_ok(input logic [XW-1:0] idx);
		reg_ok = 32'(idx) < REGISTER_COUNT;
	endfunction

	// input fields
	lseu_pkg::op_t   op_in;
	logic [XW-1:0]   first_in;
	logic            a_is_reg_in;
	logic [XW-1:0]   a_reg_in;
	logic [DW-1:0]   a_imm_in;
	logic            b_is_reg_in;
	logic [XW-1:0]   b_reg_in;
	logic [DW-1:0]   b_imm_in;
	logic [TW-1:0]   target_in;
	logic [XW-1:0]   p0_idx_in;

	assign op_in       = lseu_pkg::op_t'(s_axis_tdata[4:0]);
	assign first_in    = s_axis_tdata[8:5];
	assign a_is_reg_in = s_axis_tdata[9];
	assign a_reg_in    = s_axis_tdata[13:10];
	assign a_imm_in    = s_axis_tdata[45:14];
	assign b_is_reg_in = s_axis_tdata[46];
	assign b_reg_in    = s_axis_tdata[50:47];
	assign b_imm_in    = s_axis_tdata[82:51];
	assign target_in   = s_axis_tdata[92:83];
	assign p0_idx_in   = (op_in == lseu_pkg::OP_STR) ? first_in : a_reg_in;

	// control state
	logic                    v_s1_q, v_s2_q;
	logic                    out_valid_q;
	logic [DW-1:0]           out_value_q;
	logic [PW-1:0]           out_pc_q;
	logic [1:0]              out_status_q;
	logic [1:0]              out_flag_q;
	logic [PW-1:0]           pc_q;
	logic [1:0]              flag_q;
	lseu_pkg::status_t       halt_q;
	logic [PW-1:0]           plen_q;
	logic                    clr_busy_q;
	logic [MAW-1:0]          clr_idx_q;
	logic [REGISTER_COUNT-1:0] rf_valid_q;

	// stage 1 registers
	lseu_pkg::op_t  op_s1;
	logic [XW-1:0]  first_s1;
	logic           a_is_reg_s1, b_is_reg_s1;
	logic [DW-1:0]  a_imm_s1, b_imm_s1;
	logic [XW-1:0]  p0_idx_s1, p1_idx_s1;
	logic [TW-1:0]  target_s1;
	logic           fwd0_s1, fwd1_s1;
	logic [DW-1:0]  fwd_val_s1;

	// stage 2 registers
	lseu_pkg::op_t  op_s2;
	logic [XW-1:0]  first_s2;
	logic [TW-1:0]  target_s2;
	logic [DW-1:0]  alu_val_s2;
	logic [1:0]     cmp_s2;
	logic [DW-1:0]  store_val_s2;
	logic           addr_ok_s2;
	logic [MAW-1:0] mem_addr_s2;

	logic            accept, out_free, s2_adv, s1_adv;
	logic [DW-1:0]   rf0_rdata, rf1_rdata, dm_rdata;
	logic [DW-1:0]   rd0, rd1, a_val, b_val;
	logic            addr_ok;
	lseu_pkg::alu_res_t alu_res;

	logic                rf_we, mem_we;
	logic [DW-1:0]       wb_val;
	logic [PW-1:0]       nxt_pc, res_pc;
	lseu_pkg::status_t   nxt_halt, res_status;
	logic [1:0]          res_flag;
	logic                take;
	logic [31:0]         limit;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s2_adv        = v_s2_q && out_free;
	assign s1_adv        = v_s1_q;
	assign s_axis_tready = !clr_busy_q && !v_s1_q && (!v_s2_q || s2_adv);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// register file, two read ports kept as two written-together copies
	lseu_ram #(.WIDTH(DW), .DEPTH(REGISTER_COUNT)) u_rf0 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (RAW'(first_s2)),
		.wdata (wb_val),
		.re    (accept),
		.raddr (RAW'(p0_idx_in)),
		.rdata (rf0_rdata)
	);

	lseu_ram #(.WIDTH(DW), .DEPTH(REGISTER_COUNT)) u_rf1 (
		.clk   (clk),
		.we    (rf_we),
		.waddr (RAW'(first_s2)),
		.wdata (wb_val),
		.re    (accept),
		.raddr (RAW'(b_reg_in)),
		.rdata (rf1_rdata)
	);

	lseu_ram #(.WIDTH(DW), .DEPTH(MEMORY_WORDS)) u_dmem (
		.clk   (clk),
		.we    (clr_busy_q || mem_we),
		.waddr (clr_busy_q ? clr_idx_q : mem_addr_s2),
		.wdata (clr_busy_q ? '0 : store_val_s2),
		.re    (s1_adv),
		.raddr (b_val[MAW-1:0]),
		.rdata (dm_rdata)
	);

	// stage 1: operand select with forwarding, alu, address check
	always_comb begin
		if (fwd0_s1) begin
			rd0 = fwd_val_s1;
		end else if (reg_ok(p0_idx_s1) && rf_valid_q[RAW'(p0_idx_s1)]) begin
			rd0 = rf0_rdata;
		end else begin
			rd0 = '0;
		end
		if (fwd1_s1) begin
			rd1 = fwd_val_s1;
		end else if (reg_ok(p1_idx_s1) && rf_valid_q[RAW'(p1_idx_s1)]) begin
			rd1 = rf1_rdata;
		end else begin
			rd1 = '0;
		end
		a_val   = a_is_reg_s1 ? rd0 : a_imm_s1;
		b_val   = b_is_reg_s1 ? rd1 : b_imm_s1;
		addr_ok = !b_val[DW-1] && (b_val < 32'(MEMORY_WORDS));
	end

	lseu_alu u_alu (
		.op  (op_s1),
		.a   (a_val),
		.b   (b_val),
		.res (alu_res)
	);

	// stage 2: state update and writeback
	always_comb begin
		take     = 1'b0;
		nxt_halt = lseu_pkg::ST_RUN;
		wb_val   = '0;
		res_flag = flag_q;
		rf_we    = 1'b0;
		mem_we   = 1'b0;
		unique case (op_s2)
			lseu_pkg::OP_MOV, lseu_pkg::OP_ADD, lseu_pkg::OP_SUB,
			lseu_pkg::OP_LSL, lseu_pkg::OP_LSR: begin
				wb_val = alu_val_s2;
				rf_we  = reg_ok(first_s2);
			end
			lseu_pkg::OP_LDR: begin
				if (addr_ok_s2) begin
					wb_val = dm_rdata;
					rf_we  = reg_ok(first_s2);
				end else begin
					nxt_halt = lseu_pkg::ST_FAULT;
				end
			end
			lseu_pkg::OP_STR: begin
				if (addr_ok_s2) begin
					wb_val = store_val_s2;
					mem_we = 1'b1;
				end else begin
					nxt_halt = lseu_pkg::ST_FAULT;
				end
			end
			lseu_pkg::OP_CMP: res_flag = cmp_s2;
			lseu_pkg::OP_B:   take = 1'b1;
			lseu_pkg::OP_BEQ: take = (flag_q == lseu_pkg::CMP_EQ);
			lseu_pkg::OP_BNE: take = (flag_q != lseu_pkg::CMP_EQ);
			lseu_pkg::OP_BLT: take = (flag_q == lseu_pkg::CMP_LT);
			lseu_pkg::OP_BLE: take = (flag_q != lseu_pkg::CMP_GT);
			lseu_pkg::OP_BGT: take = (flag_q == lseu_pkg::CMP_GT);
			lseu_pkg::OP_BGE: take = (flag_q != lseu_pkg::CMP_LT);
			lseu_pkg::OP_RET: nxt_halt = lseu_pkg::ST_RET;
			default: ;
		endcase
		nxt_pc = take ? (PW'(target_s2) + PW'(1)) : (pc_q + PW'(1));
		limit  = (32'(plen_q) < 32'(PROGRAM_LINES)) ? 32'(plen_q) : 32'(PROGRAM_LINES);
		if (nxt_halt == lseu_pkg::ST_RUN && 32'(nxt_pc) >= limit) begin
			nxt_halt = lseu_pkg::ST_PAST;
		end
		res_pc     = nxt_pc;
		res_status = nxt_halt;
		if (halt_q != lseu_pkg::ST_RUN) begin
			res_pc     = pc_q;
			res_status = halt_q;
			res_flag   = flag_q;
			wb_val     = '0;
			rf_we      = 1'b0;
			mem_we     = 1'b0;
		end
		rf_we  = rf_we && s2_adv;
		mem_we = mem_we && s2_adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pc_q         <= '0;
			flag_q       <= lseu_pkg::CMP_EQ;
			halt_q       <= lseu_pkg::ST_RUN;
			plen_q       <= '0;
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			rf_valid_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				plen_q <= cfg_data;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + MAW'(1);
				if (clr_idx_q == MAW'(MEMORY_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			v_s1_q <= accept;
			if (s1_adv) begin
				v_s2_q <= 1'b1;
			end else if (s2_adv) begin
				v_s2_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
				pc_q        <= res_pc;
				halt_q      <= res_status;
				flag_q      <= res_flag;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (rf_we) begin
				rf_valid_q[RAW'(first_s2)] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			first_s1    <= first_in;
			a_is_reg_s1 <= a_is_reg_in;
			a_imm_s1    <= a_imm_in;
			b_is_reg_s1 <= b_is_reg_in;
			b_imm_s1    <= b_imm_in;
			p0_idx_s1   <= p0_idx_in;
			p1_idx_s1   <= b_reg_in;
			target_s1   <= target_in;
			fwd0_s1     <= rf_we && (first_s2 == p0_idx_in);
			fwd1_s1     <= rf_we && (first_s2 == b_reg_in);
			fwd_val_s1  <= wb_val;
		end
		if (s1_adv) begin
			op_s2        <= op_s1;
			first_s2     <= first_s1;
			target_s2    <= target_s1;
			alu_val_s2   <= alu_res.value;
			cmp_s2       <= alu_res.cmp;
			store_val_s2 <= rd0;
			addr_ok_s2   <= addr_ok;
			mem_addr_s2  <= b_val[MAW-1:0];
		end
		if (s2_adv) begin
			out_pc_q     <= res_pc;
			out_status_q <= res_status;
			out_value_q  <= wb_val;
			out_flag_q   <= res_flag;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_flag_q, out_value_q, out_status_q, out_pc_q};

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clr_busy_q)
		else $error("transaction accepted during memory clear");

	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1_q && v_s2_q))
		else $error("two instructions in flight");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(halt_q != lseu_pkg::ST_RUN) |=> (halt_q == $past(halt_q)))
		else $error("halt status changed after halt");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_we && mem_we))
		else $error("register and memory written together");
`endif

endmodule

`default_nettype wire

// File: sim/load_store_execute_unit_tb.sv
`timescale 1ns / 100ps
// load_store_execute_unit_tb: self-checking bench for the load/store execute unit
// drives instruction streams and program length writes, predicts each result
// in-bench and compares it field by field; depends on lseu_pkg and the rtl

module load_store_execute_unit_tb;

	localparam int DATA_W = lseu_pkg::DATA_W;
	localparam int PC_W   = lseu_pkg::PC_W;
	localparam int IDX_W  = lseu_pkg::IDX_W;
	localparam int TGT_W  = lseu_pkg::TGT_W;
	localparam int OP_W   = lseu_pkg::OP_W;
	localparam int IN_W   = lseu_pkg::IN_W;
	localparam int OUT_W  = lseu_pkg::OUT_W;
	localparam int REG_N  = lseu_pkg::REG_COUNT_DEF;
	localparam int MEM_N  = lseu_pkg::MEMORY_WORDS_DEF;
	localparam int PROG_N = lseu_pkg::PROGRAM_LINES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [OP_W-1:0] OP_SPARE_LAST = 5'd31;

	typedef struct packed {
		logic [TGT_W-1:0]  target_line;
		logic [DATA_W-1:0] b_imm;
		logic [IDX_W-1:0]  b_reg;
		logic              b_is_reg;
		logic [DATA_W-1:0] a_imm;
		logic [IDX_W-1:0]  a_reg;
		logic              a_is_reg;
		logic [IDX_W-1:0]  first_reg;
		logic [OP_W-1:0]   operation;
	} instr_t;

	typedef struct packed {
		logic [1:0]          compare_state;
		logic [DATA_W-1:0]   result_value;
		lseu_pkg::status_t   status;
		logic [PC_W-1:0]     next_pc;
	} retire_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [PC_W-1:0]   cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;

	// predicted machine state
	logic [DATA_W-1:0] gpr [REG_N];
	logic [DATA_W-1:0] dmem [MEM_N];
	logic [PC_W-1:0]   pc_now;
	logic [1:0]        flag_now;
	lseu_pkg::status_t run_state;
	logic [PC_W-1:0]   prog_len;

	retire_t     retire_fifo [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic        steady = 1'b0;

	load_store_execute_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[load_store_execute_unit] ERROR");
			$finish;
		end
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic int eff_limit();
		return (int'(prog_len) < PROG_N) ? int'(prog_len) : PROG_N;
	endfunction

	function automatic logic [DATA_W-1:0] read_gpr(input logic [IDX_W-1:0] idx);
		return (idx < REG_N) ? gpr[idx] : '0;
	endfunction

	function automatic logic [DATA_W-1:0] fetch_a(input instr_t ins);
		return ins.a_is_reg ? read_gpr(ins.a_reg) : ins.a_imm;
	endfunction

	function automatic logic [DATA_W-1:0] fetch_b(input instr_t ins);
		return ins.b_is_reg ? read_gpr(ins.b_reg) : ins.b_imm;
	endfunction

	function automatic retire_t retire_instr(input instr_t ins);
		retire_t           r;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] val;
		logic              take;
		logic              wr;
		a = fetch_a(ins);
		b = fetch_b(ins);
		val = '0;
		take = 1'b0;
		wr = 1'b0;
		if (run_state == lseu_pkg::ST_RUN) begin
			pc_now = pc_now + 1'b1;
			case (ins.operation)
				lseu_pkg::OP_MOV: begin val = a; wr = 1'b1; end
				lseu_pkg::OP_ADD: begin val = a + b; wr = 1'b1; end
				lseu_pkg::OP_SUB: begin val = a - b; wr = 1'b1; end
				lseu_pkg::OP_LSL: begin val = a << b[4:0]; wr = 1'b1; end
				lseu_pkg::OP_LSR: begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
				lseu_pkg::OP_LDR, lseu_pkg::OP_STR: begin
					if ($signed(b) < 0 || $signed(b) >= MEM_N) begin
						run_state = lseu_pkg::ST_FAULT;
					end else if (ins.operation == lseu_pkg::OP_LDR) begin
						val = dmem[b];
						wr = 1'b1;
					end else begin
						val = read_gpr(ins.first_reg);
						dmem[b] = val;
					end
				end
				lseu_pkg::OP_CMP: flag_now = ($signed(a) < $signed(b)) ? lseu_pkg::CMP_LT :
					(($signed(a) > $signed(b)) ? lseu_pkg::CMP_GT : lseu_pkg::CMP_EQ);
				lseu_pkg::OP_B:   take = 1'b1;
				lseu_pkg::OP_BEQ: take = (flag_now == lseu_pkg::CMP_EQ);
				lseu_pkg::OP_BNE: take = (flag_now != lseu_pkg::CMP_EQ);
				lseu_pkg::OP_BLT: take = (flag_now == lseu_pkg::CMP_LT);
				lseu_pkg::OP_BLE: take = (flag_now != lseu_pkg::CMP_GT);
				lseu_pkg::OP_BGT: take = (flag_now == lseu_pkg::CMP_GT);
				lseu_pkg::OP_BGE: take = (flag_now != lseu_pkg::CMP_LT);
				lseu_pkg::OP_RET: run_state = lseu_pkg::ST_RET;
				default: ;
			endcase
			if (wr && ins.first_reg < REG_N) gpr[ins.first_reg] = val;
			if (take) pc_now = PC_W'(ins.target_line) + 1'b1;
			if (run_state == lseu_pkg::ST_RUN && int'(pc_now) >= eff_limit())
				run_state = lseu_pkg::ST_PAST;
			if (run_state == lseu_pkg::ST_FAULT) val = '0;
		end
		r.next_pc = pc_now;
		r.status = run_state;
		r.result_value = val;
		r.compare_state = flag_now;
		return r;
	endfunction

	function automatic instr_t asm_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] rd,
			input logic a_sel, input logic [IDX_W-1:0] ra, input logic [DATA_W-1:0] ai,
			input logic b_sel, input logic [IDX_W-1:0] rb, input logic [DATA_W-1:0] bi,
			input logic [TGT_W-1:0] tgt);
		instr_t ins;
		ins.operation = op;
		ins.first_reg = rd;
		ins.a_is_reg = a_sel;
		ins.a_reg = ra;
		ins.a_imm = ai;
		ins.b_is_reg = b_sel;
		ins.b_reg = rb;
		ins.b_imm = bi;
		ins.target_line = tgt;
		return ins;
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0, 1: return $urandom_range(0, 300);
			2: return ~32'($urandom_range(0, 39));
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return '0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_reg();
		if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(REG_N, 15));
		return IDX_W'($urandom_range(0, REG_N - 1));
	endfunction

	// well-formed item: in-range addresses, branches inside the program, no halt
	function automatic instr_t rand_instr();
		instr_t            ins;
		int                lim;
		logic [DATA_W-1:0] addr;
		lim = eff_limit();
		if ($urandom_range(0, 9) == 0)
			ins.operation = OP_W'($urandom_range(int'(lseu_pkg::OP_RET) + 1,
				int'(OP_SPARE_LAST)));
		else
			ins.operation = OP_W'($urandom_range(int'(lseu_pkg::OP_NOP),
				int'(lseu_pkg::OP_BGE)));
		ins.first_reg = rand_reg();
		ins.a_is_reg = 1'($urandom_range(0, 1));
		ins.a_reg = rand_reg();
		ins.a_imm = rand_word();
		ins.b_is_reg = 1'($urandom_range(0, 1));
		ins.b_reg = rand_reg();
		ins.b_imm = rand_word();
		ins.target_line = TGT_W'($urandom_range(0, (lim >= 2) ? lim - 2 : 0));
		addr = fetch_b(ins);
		if ((ins.operation == lseu_pkg::OP_LDR || ins.operation == lseu_pkg::OP_STR)
				&& ($signed(addr) < 0 || $signed(addr) >= MEM_N)) begin
			ins.b_is_reg = 1'b0;
			ins.b_imm = $urandom_range(0, MEM_N - 1);
		end
		if (int'(pc_now) + 1 >= lim) ins.operation = lseu_pkg::OP_B;
		return ins;
	endfunction

	function automatic void compare_field(input string name, input logic [DATA_W-1:0] exp_v,
			input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
		end
	endfunction

	task automatic issue(input instr_t ins);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - $bits(instr_t)){1'b0}}, ins};
		do @(posedge clk); while (!s_axis_tready);
		retire_fifo.push_back(retire_instr(ins));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (retire_fifo.size() != 0) @(negedge clk);
	endtask

	task automatic write_prog_len(input logic [PC_W-1:0] v);
		drain();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		prog_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		write_prog_len(11'd0);
		write_prog_len(11'h7ff);
		issue(asm_op(lseu_pkg::OP_MOV, 4'd0, 1'b0, 4'd0, 32'h7fff_ffff, 1'b0, 4'd0, 32'd0,
			10'd0));
		issue(asm_op(lseu_pkg::OP_MOV, 4'd1, 1'b0, 4'd0, 32'h8000_0000, 1'b0, 4'd0, 32'd0,
			10'd0));
		// overflow wraps both ways
		issue(asm_op(lseu_pkg::OP_ADD, 4'd2, 1'b1, 4'd0, 32'd0, 1'b0, 4'd0, 32'd1, 10'd0));
		issue(asm_op(lseu_pkg::OP_SUB, 4'd3, 1'b1, 4'd1, 32'd0, 1'b0, 4'd0, 32'd1, 10'd0));
		// shift amounts use the low five bits only
		issue(asm_op(lseu_pkg::OP_LSL, 4'd4, 1'b0, 4'd0, 32'd1, 1'b0, 4'd0, 32'd31, 10'd0));
		issue(asm_op(lseu_pkg::OP_LSL, 4'd5, 1'b0, 4'd0, 32'hffff_ffff, 1'b0, 4'd0, 32'd32,
			10'd0));
		issue(asm_op(lseu_pkg::OP_LSR, 4'd6, 1'b1, 4'd1, 32'd0, 1'b0, 4'd0, 32'd31, 10'd0));
		issue(asm_op(lseu_pkg::OP_LSR, 4'd7, 1'b0, 4'd0, 32'h4000_0000, 1'b0, 4'd0,
			32'hffff_ffe1, 10'd0));
		issue(asm_op(lseu_pkg::OP_STR, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'(MEM_N - 1),
			10'd0));
		issue(asm_op(lseu_pkg::OP_STR, 4'd1, 1'b0, 4'd0, 32'd0, 1'b1, 4'd8, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_LDR, 4'd9, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'(MEM_N - 1),
			10'd0));
		// register beyond the file reads zero, writes to it are dropped
		issue(asm_op(lseu_pkg::OP_LDR, 4'd9, 1'b0, 4'd0, 32'd0, 1'b1, 4'd15, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_MOV, 4'd12, 1'b0, 4'd0, 32'd5, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_MOV, 4'd2, 1'b1, 4'd12, 32'd0, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_CMP, 4'd0, 1'b1, 4'd0, 32'd0, 1'b1, 4'd1, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_BGT, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd10));
		issue(asm_op(lseu_pkg::OP_BLT, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd100));
		issue(asm_op(lseu_pkg::OP_CMP, 4'd0, 1'b1, 4'd1, 32'd0, 1'b1, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_BLE, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd20));
		issue(asm_op(lseu_pkg::OP_BGE, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd200));
		issue(asm_op(lseu_pkg::OP_BNE, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd30));
		issue(asm_op(lseu_pkg::OP_CMP, 4'd0, 1'b0, 4'd0, 32'd5, 1'b0, 4'd0, 32'd5, 10'd0));
		issue(asm_op(lseu_pkg::OP_BEQ, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd40));
		issue(asm_op(lseu_pkg::OP_B, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_NOP, 4'd3, 1'b1, 4'd2, 32'hffff_ffff, 1'b1, 4'd3,
			32'hffff_ffff, 10'h3ff));
		issue(asm_op(OP_SPARE_LAST, 4'd0, 1'b0, 4'd0, 32'd7, 1'b0, 4'd0, 32'd7, 10'd0));
	endtask

	task automatic test_random();
		logic [PC_W-1:0] len;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: len = 11'h7ff;
				1: len = 11'd2;
				3: len = 11'd1024;
				5: len = PC_W'($urandom_range(3, 40));
				default: len = PC_W'($urandom_range(2, 1024));
			endcase
			write_prog_len(len);
			repeat ((p == 1) ? 60 : 380) begin
				if ($urandom_range(0, 63) == 0) steady = !steady;
				issue(rand_instr());
			end
		end
		steady = 1'b0;
	endtask

	// one way to halt per run, then items that must see the frozen state
	task automatic test_halt();
		write_prog_len(11'd1024);
		issue(asm_op(lseu_pkg::OP_B, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd0));
		case ($urandom_range(0, 4))
			0: issue(asm_op(lseu_pkg::OP_RET, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0,
				10'd0));
			1: issue(asm_op(lseu_pkg::OP_LDR, 4'd3, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0,
				$urandom_range(0, 1) ? 32'(MEM_N) : 32'h8000_0000, 10'd0));
			2: begin
				issue(asm_op(lseu_pkg::OP_MOV, 4'd0, 1'b0, 4'd0, 32'hffff_ffff, 1'b0, 4'd0,
					32'd0, 10'd0));
				issue(asm_op(lseu_pkg::OP_STR, 4'd1, 1'b0, 4'd0, 32'd0, 1'b1, 4'd0, 32'd0,
					10'd0));
			end
			3: begin
				write_prog_len(11'd0);
				issue(asm_op(lseu_pkg::OP_NOP, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0,
					10'd0));
			end
			default: issue(asm_op(lseu_pkg::OP_B, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0,
				10'h3ff));
		endcase
		issue(asm_op(lseu_pkg::OP_RET, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_MOV, 4'd0, 1'b0, 4'd0, 32'd1, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_STR, 4'd0, 1'b0, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0, 10'd0));
		issue(asm_op(lseu_pkg::OP_CMP, 4'd0, 1'b0, 4'd0, 32'd1, 1'b0, 4'd0, 32'd2, 10'd0));
	endtask

	initial begin : result_check
		int      gap;
		retire_t exp_r;
		retire_t got;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = retire_t'(m_axis_tdata[$bits(retire_t)-1:0]);
			if (retire_fifo.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transaction, expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				exp_r = retire_fifo.pop_front();
				compare_field("next_pc", DATA_W'(exp_r.next_pc), DATA_W'(got.next_pc));
				compare_field("status", DATA_W'(exp_r.status), DATA_W'(got.status));
				compare_field("result_value", exp_r.result_value, got.result_value);
				compare_field("compare_state", DATA_W'(exp_r.compare_state),
					DATA_W'(got.compare_state));
			end
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		for (int i = 0; i < REG_N; i++) gpr[i] = '0;
		for (int i = 0; i < MEM_N; i++) dmem[i] = '0;
		pc_now = '0;
		flag_now = lseu_pkg::CMP_EQ;
		run_state = lseu_pkg::ST_RUN;
		prog_len = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_halt();
		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("[load_store_execute_unit] OK");
		else
			$display("[load_store_execute_unit] ERROR");
		$finish;
	end

endmodule
